// ===== src/bpsq_pkg.sv =====
// Shared types, codes and reset values for the buzzer pattern sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bpsq_pkg;

    // Width of the millisecond counter by default, and its widest legal value.
    localparam int MS_WIDTH_DEF = 16;
    localparam int MS_WIDTH_MAX = 32;

    // Configuration registers are all 16 bits wide.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_GAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_BEEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHIRP     = 3'd4;

    // Reset values of the duration registers, in milliseconds.
    localparam logic [CFG_W-1:0] ALARM_ON_RST  = 16'd60;
    localparam logic [CFG_W-1:0] ALARM_OFF_RST = 16'd60;
    localparam logic [CFG_W-1:0] ALARM_GAP_RST = 16'd300;
    localparam logic [CFG_W-1:0] TEST_BEEP_RST = 16'd150;
    localparam logic [CFG_W-1:0] CHIRP_RST     = 16'd50;

    // Command codes of an input beat.
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Pattern codes.
    typedef enum logic [1:0] {
        PAT_OFF   = 2'd0,
        PAT_ALARM = 2'd1,
        PAT_TEST  = 2'd2,
        PAT_CHIRP = 2'd3
    } pattern_t;

    // Duration registers as seen by the step logic.
    typedef struct packed {
        logic [CFG_W-1:0] alarm_on_ms;
        logic [CFG_W-1:0] alarm_off_ms;
        logic [CFG_W-1:0] alarm_gap_ms;
        logic [CFG_W-1:0] test_beep_ms;
        logic [CFG_W-1:0] chirp_ms;
    } cfg_regs_t;

    // Input beat.
    typedef struct packed {
        logic       command;
        logic [1:0] pattern;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic       buzzer_on;
        logic       done_res;
        logic [1:0] active_pattern;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== src/buzzer_pattern_sequencer_top.sv =====
// Top level of the buzzer pattern sequencer.
//
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_stall    in_data (command, pattern)
//  out       output     out_valid/out_stall  out_data (buzzer_on, done_res, active_pattern)
//  cfg       input      cfg_we               cfg_index, cfg_data
//
// One beat is accepted per cycle while in_stall is low; the one-pass step update between
// the state and result registers sets its result, registered in the output buffer.
// Reset clears the pattern state and loads the default durations; no clearing pass.
// A stalled output holds its result while a skid stage takes one more beat; in_stall
// rises only when both output entries are full.
`timescale 1ns / 1ps
`default_nettype none

module buzzer_pattern_sequencer_top #(
    parameter int MS_WIDTH = bpsq_pkg::MS_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire bpsq_pkg::in_beat_t             in_data,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      bpsq_pkg::out_beat_t            out_data,
    input  wire logic                           cfg_we,
    input  wire logic [bpsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpsq_pkg::CFG_W-1:0]     cfg_data
);

    bpsq_pkg::cfg_regs_t regs;
    bpsq_pkg::out_beat_t result;
    logic                accept;
    logic                full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Duration registers.
    bpsq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // Pattern state and step update.
    bpsq_core #(
        .MS_WIDTH (MS_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (in_data),
        .regs   (regs),
        .result (result)
    );

    // Result register and skid stage.
    bpsq_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== src/bpsq_cfg.sv =====
// Duration register file written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module bpsq_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [bpsq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bpsq_pkg::CFG_W-1:0]     cfg_data,
    output      bpsq_pkg::cfg_regs_t            regs
);

    bpsq_pkg::cfg_regs_t regs_reg;

    // Register writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.alarm_on_ms  <= bpsq_pkg::ALARM_ON_RST;
            regs_reg.alarm_off_ms <= bpsq_pkg::ALARM_OFF_RST;
            regs_reg.alarm_gap_ms <= bpsq_pkg::ALARM_GAP_RST;
            regs_reg.test_beep_ms <= bpsq_pkg::TEST_BEEP_RST;
            regs_reg.chirp_ms     <= bpsq_pkg::CHIRP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpsq_pkg::REG_ALARM_ON:  regs_reg.alarm_on_ms  <= cfg_data;
                bpsq_pkg::REG_ALARM_OFF: regs_reg.alarm_off_ms <= cfg_data;
                bpsq_pkg::REG_ALARM_GAP: regs_reg.alarm_gap_ms <= cfg_data;
                bpsq_pkg::REG_TEST_BEEP: regs_reg.test_beep_ms <= cfg_data;
                bpsq_pkg::REG_CHIRP:     regs_reg.chirp_ms     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

`default_nettype wire

// ===== src/bpsq_core.sv =====
// Pattern state registers and the single-pass step update for one beat.
`timescale 1ns / 1ps
`default_nettype none

module bpsq_core #(
    parameter int MS_WIDTH = bpsq_pkg::MS_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire bpsq_pkg::in_beat_t  beat,
    input  wire bpsq_pkg::cfg_regs_t regs,
    output      bpsq_pkg::out_beat_t result
);

    localparam logic [2:0] ALARM_GAP_STEP = 3'd5;
    localparam logic [2:0] ALARM_STEPS    = 3'd6;
    localparam logic [2:0] SHOT_STEPS     = 3'd2;
    localparam logic [2:0] FIRST_STEP     = 3'd0;

    bpsq_pkg::pattern_t  pattern_reg, pattern_next;
    logic [2:0]          step_reg, step_next;
    logic [MS_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                finished_reg, finished_next;
    logic                drive_reg, drive_next;

    logic [bpsq_pkg::CFG_W-1:0]        dur_raw;
    logic [bpsq_pkg::MS_WIDTH_MAX-1:0] dur_wide;
    logic [MS_WIDTH-1:0]               dur;
    logic [MS_WIDTH:0]                 elapsed_inc;
    logic [2:0]                        step_inc;
    bpsq_pkg::pattern_t                req_pattern;

    // Level that a step drives.
    function automatic logic step_on(bpsq_pkg::pattern_t pat, logic [2:0] idx);
        logic lvl;
        lvl = 1'b0;
        unique case (pat)
            bpsq_pkg::PAT_ALARM: lvl = (idx == 3'd0) || (idx == 3'd2) || (idx == 3'd4);
            bpsq_pkg::PAT_TEST,
            bpsq_pkg::PAT_CHIRP: lvl = (idx == FIRST_STEP);
            bpsq_pkg::PAT_OFF:   lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    // Number of steps in a pattern.
    function automatic logic [2:0] step_count(bpsq_pkg::pattern_t pat);
        logic [2:0] n;
        n = 3'd0;
        unique case (pat)
            bpsq_pkg::PAT_ALARM: n = ALARM_STEPS;
            bpsq_pkg::PAT_TEST,
            bpsq_pkg::PAT_CHIRP: n = SHOT_STEPS;
            bpsq_pkg::PAT_OFF:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Duration of the current step, cut to the counter width.
    always_comb
    begin
        dur_raw = '0;
        unique case (pattern_reg)
            bpsq_pkg::PAT_ALARM:
            begin
                if (step_reg == ALARM_GAP_STEP)
                    dur_raw = regs.alarm_gap_ms;
                else if (step_on(bpsq_pkg::PAT_ALARM, step_reg))
                    dur_raw = regs.alarm_on_ms;
                else
                    dur_raw = regs.alarm_off_ms;
            end
            bpsq_pkg::PAT_TEST:
                dur_raw = (step_reg == FIRST_STEP) ? regs.test_beep_ms : '0;
            bpsq_pkg::PAT_CHIRP:
                dur_raw = (step_reg == FIRST_STEP) ? regs.chirp_ms : '0;
            bpsq_pkg::PAT_OFF:
                dur_raw = '0;
        endcase
        dur_wide = bpsq_pkg::MS_WIDTH_MAX'(dur_raw);
        dur      = dur_wide[MS_WIDTH-1:0];
    end

    assign elapsed_inc = {1'b0, elapsed_reg} + (MS_WIDTH + 1)'(1);
    assign step_inc    = step_reg + 3'd1;
    assign req_pattern = bpsq_pkg::pattern_t'(beat.pattern);

    // Next state for a set command or a tick.
    always_comb
    begin
        pattern_next  = pattern_reg;
        step_next     = step_reg;
        elapsed_next  = elapsed_reg;
        finished_next = finished_reg;
        drive_next    = drive_reg;
        if (beat.command == bpsq_pkg::CMD_TICK)
        begin
            if (pattern_reg != bpsq_pkg::PAT_OFF && !finished_reg)
            begin
                if (elapsed_inc < {1'b0, dur})
                begin
                    // Still inside the step; the counter saturates at its top.
                    elapsed_next = (&elapsed_reg) ? elapsed_reg
                                                  : elapsed_inc[MS_WIDTH-1:0];
                end
                else if (step_inc >= step_count(pattern_reg)
                         && pattern_reg != bpsq_pkg::PAT_ALARM)
                begin
                    // A one-shot pattern ran out of steps.
                    step_next     = step_inc;
                    drive_next    = 1'b0;
                    finished_next = 1'b1;
                    pattern_next  = bpsq_pkg::PAT_OFF;
                end
                else
                begin
                    step_next    = (step_inc >= step_count(pattern_reg)) ? FIRST_STEP
                                                                         : step_inc;
                    elapsed_next = '0;
                    drive_next   = step_on(pattern_reg, step_next);
                end
            end
        end
        else if (req_pattern != pattern_reg)
        begin
            pattern_next = req_pattern;
            if (req_pattern == bpsq_pkg::PAT_OFF)
            begin
                drive_next    = 1'b0;
                finished_next = 1'b1;
            end
            else
            begin
                step_next     = FIRST_STEP;
                elapsed_next  = '0;
                finished_next = 1'b0;
                drive_next    = step_on(req_pattern, FIRST_STEP);
            end
        end
    end

    // State registers, updated on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= bpsq_pkg::PAT_OFF;
            step_reg     <= FIRST_STEP;
            elapsed_reg  <= '0;
            finished_reg <= 1'b0;
            drive_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pattern_reg  <= pattern_next;
            step_reg     <= step_next;
            elapsed_reg  <= elapsed_next;
            finished_reg <= finished_next;
            drive_reg    <= drive_next;
        end
    end

    // The result reports the state after this beat.
    assign result.buzzer_on      = drive_next;
    assign result.done_res       = finished_next;
    assign result.active_pattern = pattern_next;

`ifndef SYNTHESIS
    // A finished pattern never leaves the buzzer sounding.
    a_finished_silent: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !drive_reg)
        else $error("buzzer sounding after pattern finished");

    // With no pattern in force the buzzer is silent.
    a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pattern_reg == bpsq_pkg::PAT_OFF) |-> !drive_reg)
        else $error("buzzer sounding with pattern off");

    // An accepted set of a new pattern lands in the state register.
    a_set_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && beat.command == bpsq_pkg::CMD_SET)
        |=> (pattern_reg == bpsq_pkg::pattern_t'($past(beat.pattern))))
        else $error("set command not taken");
`endif

endmodule

`default_nettype wire

// ===== src/bpsq_obuf.sv =====
// Two-entry output buffer: result register with a skid stage behind it.
`timescale 1ns / 1ps
`default_nettype none

module bpsq_obuf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bpsq_pkg::out_beat_t push_data,
    output      logic                full,
    output      logic                out_valid,
    input  wire logic                out_stall,
    output      bpsq_pkg::out_beat_t out_data
);

    logic                out_valid_reg;
    bpsq_pkg::out_beat_t out_data_reg;
    logic                skid_valid_reg;
    bpsq_pkg::out_beat_t skid_data_reg;
    logic                pop;

    assign pop = out_valid_reg && !out_stall;

    // Control: the skid stage only fills while the result register is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= 1'b0;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // The skid stage holds a beat only behind a waiting result.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage filled with result register empty");

    // A beat pushed while the result is held goes to the skid stage.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("beat lost while output stalled");
`endif

endmodule

`default_nettype wire
